FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of clk, off while rst_n is low.
`define ASSERT_CLKRST(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on the module clock and reset.
`define ASSERT_CHK(name, prop) `ASSERT_CLKRST(name, clk_i, rst_ni, prop)

`endif

FILE: rtl/wg_pkg.sv
// Types, constants and saturation helper for the waveform generator.
package wg_pkg;

  localparam int MUL_W = 33;
  localparam int OUT_W = 224;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_RAMP     = 2'd3
  } wave_e;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_FREQ = 2'd1,
    CFG_AMP  = 2'd2,
    CFG_OFF  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_PH,
    ST_PHASE,
    ST_QUAD,
    ST_SINE,
    ST_UNIT,
    ST_SCALE,
    ST_STATS,
    ST_DIV_GO,
    ST_DIV,
    ST_OUT
  } st_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(S32_MAX)) return S32_MAX;
    if (v < 66'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/waveform_generator_with_stats.sv
// Waveform generator with running count, sum, min, max and average.
// A sample transfer steps through the shared multiplier, the quarter-wave ROM lookup (sine
// only), the scaling and the statistics update, then starts the divider, runs the
// two-bit-per-cycle division for the average with its done flag, and loads the output
// register; the next item can be accepted once the result has been loaded. A restart
// transfer clears the statistics at acceptance and goes straight to the output register
// load with an all-zero result. One item is in flight at a time; s_axis_tready is high
// only while the sequencer is idle, a result may wait in the output register while the
// next item is already being worked on, and a finished item holds the sequencer while
// the output register is still full.
`include "assert_macros.svh"

module waveform_generator_with_stats import wg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS        = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // sample_time
  input  logic               s_axis_tuser,  // kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // value, sample_count, value_sum, min_value, max_value, average_value
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int UW = FRAC_BITS + 4;
  localparam logic signed [UW-1:0] UnitOne = UW'(64'd1 << FRAC_BITS);
  localparam logic signed [65:0]   HalfOne = 66'(64'd1 << (FRAC_BITS - 1));

  st_e state_q, state_d;

  wave_e              mode_q;
  logic [27:0]        freq_q;
  logic signed [31:0] amp_q, off_q;

  logic [31:0]        count_q, count_d;
  logic signed [63:0] sum_q, sum_d;
  logic signed [31:0] low_q, low_d, high_q, high_d;

  logic [31:0]        t_q;
  logic               kind_q;
  logic [FRAC_BITS-1:0] ph_q;
  logic               neg_q;
  logic signed [31:0] val_q, val_d;

  logic               in_xfer, out_load, div_start, div_done;
  logic signed [31:0] div_quot;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  logic [FRAC_BITS-1:0] ph_w;
  logic [PW-1:0]        pos_w, r1_w, r_w;
  logic                 qhi_w, qlo_w;
  logic [AW-1:0]        rom_addr;
  logic [FRAC_BITS:0]   rom_data;
  logic signed [UW-1:0] p_s, unit_w;
  logic signed [65:0]   sc_w, tot_w;
  logic signed [64:0]   sum_ext;

  logic               m_valid_q;
  logic [OUT_W-1:0]   out_q;

  wg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  wg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .FRAC_BITS        (FRAC_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  wg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Phase, quadrant and unit waveform
  assign ph_w  = mul_p[FRAC_BITS +: FRAC_BITS];
  assign pos_w = mul_p[FRAC_BITS +: PW];

  always_comb begin
    qhi_w = pos_w >= PW'(2 * SINE_TABLE_DEPTH);
    r1_w  = qhi_w ? pos_w - PW'(2 * SINE_TABLE_DEPTH) : pos_w;
    qlo_w = r1_w >= PW'(SINE_TABLE_DEPTH);
    r_w   = qlo_w ? r1_w - PW'(SINE_TABLE_DEPTH) : r1_w;
    rom_addr = qlo_w ? AW'(SINE_TABLE_DEPTH) - AW'(r_w) : AW'(r_w);
  end

  assign p_s = signed'(UW'(ph_q));

  always_comb begin
    case (mode_q)
      WAVE_SINE:     unit_w = neg_q ? -signed'(UW'(rom_data)) : signed'(UW'(rom_data));
      WAVE_SQUARE:   unit_w = ph_q[FRAC_BITS-1] ? -UnitOne : UnitOne;
      WAVE_TRIANGLE: unit_w = ph_q[FRAC_BITS-1] ? (UnitOne + UnitOne + UnitOne) - (p_s <<< 2)
                                                : (p_s <<< 2) - UnitOne;
      WAVE_RAMP:     unit_w = (p_s <<< 1) - UnitOne;
      default:       unit_w = '0;
    endcase
  end

  // Scale and offset
  always_comb begin
    sc_w  = (mul_p + HalfOne) >>> FRAC_BITS;
    tot_w = sc_w + 66'(off_q);
    val_d = sat32(tot_w);
  end

  // Statistics update
  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    low_d   = low_q;
    high_d  = high_q;
    sum_ext = 65'(sum_q) + 65'(val_q);
    if (state_q == ST_IDLE && in_xfer && s_axis_tuser) begin
      count_d = '0;
      sum_d   = '0;
      low_d   = '0;
      high_d  = '0;
    end else if (state_q == ST_STATS) begin
      if (count_q == '0 || val_q < low_q)  low_d  = val_q;
      if (count_q == '0 || val_q > high_q) high_d = val_q;
      if (count_q != '1) count_d = count_q + 32'd1;
      if (sum_ext[64] != sum_ext[63]) begin
        sum_d = sum_ext[64] ? S64_MIN : S64_MAX;
      end else begin
        sum_d = sum_ext[63:0];
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_xfer) state_d = s_axis_tuser ? ST_OUT : ST_MUL_PH;
      ST_MUL_PH: state_d = ST_PHASE;
      ST_PHASE:  state_d = (mode_q == WAVE_SINE) ? ST_QUAD : ST_UNIT;
      ST_QUAD:   state_d = ST_SINE;
      ST_SINE:   state_d = ST_SCALE;
      ST_UNIT:   state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_STATS;
      ST_STATS:  state_d = ST_DIV_GO;
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_OUT;
      ST_OUT:    if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_MUL_PH: begin
        mul_a = MUL_W'(t_q);
        mul_b = MUL_W'(freq_q);
      end
      ST_PHASE: begin
        mul_a = MUL_W'(ph_w);
        mul_b = MUL_W'(4 * SINE_TABLE_DEPTH);
      end
      ST_SINE, ST_UNIT: begin
        mul_a = MUL_W'(amp_q);
        mul_b = MUL_W'(unit_w);
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_OUT:    out_load  = !m_valid_q || m_axis_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= WAVE_SINE;
      freq_q <= 28'd65536;
      amp_q  <= 32'sd65536;
      off_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MODE: mode_q <= wave_e'(cfg_wdata_i[1:0]);
        CFG_FREQ: freq_q <= cfg_wdata_i[27:0];
        CFG_AMP:  amp_q  <= signed'(cfg_wdata_i);
        CFG_OFF:  off_q  <= signed'(cfg_wdata_i);
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      low_q   <= '0;
      high_q  <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      t_q    <= s_axis_tdata;
      kind_q <= s_axis_tuser;
    end
    if (state_q == ST_PHASE) ph_q  <= ph_w;
    if (state_q == ST_QUAD)  neg_q <= qhi_w;
    if (state_q == ST_SCALE) val_q <= val_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= {kind_q ? 32'sd0 : div_quot, high_q, low_q, sum_q, count_q,
                kind_q ? 32'sd0 : val_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  `ASSERT_CHK(wg_marks_ordered_a, (count_q != '0) |-> (low_q <= high_q))
  `ASSERT_CHK(wg_empty_sum_zero_a, (count_q == '0) |-> (sum_q == '0))
  `ASSERT_CHK(wg_one_item_a, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

endmodule

FILE: rtl/wg_mul.sv
// Shared signed multiplier with a registered product.
module wg_mul import wg_pkg::*; (
  input  logic                          clk_i,
  input  logic signed [MUL_W-1:0]       a_i,
  input  logic signed [MUL_W-1:0]       b_i,
  output logic signed [2*MUL_W-1:0]     p_o
);

  logic signed [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/wg_sine_rom.sv
// Quarter-wave sine ROM built at elaboration, registered read.
module wg_sine_rom import wg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS        = 16,
  localparam int AW              = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic [AW-1:0]        addr_i,
  output logic [FRAC_BITS:0]   data_o
);

  function automatic logic [FRAC_BITS:0] sine_entry(input int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(i) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 210;
    t  = Q30_ONE - ((x2 * t) >> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    s = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    return s[FRAC_BITS:0];
  endfunction

  logic [FRAC_BITS:0] rom_w [SINE_TABLE_DEPTH+1];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g);
  end

  logic [FRAC_BITS:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

FILE: rtl/wg_div.sv
// Iterative signed 64 by unsigned 32 divider, two quotient bits per cycle.
`include "assert_macros.svh"

module wg_div import wg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [63:0]  dividend_i,
  input  logic [31:0]         divisor_i,
  output logic                done_o,
  output logic signed [31:0]  quot_o
);

  localparam int Steps = 2;
  localparam int Iters = 64 / Steps;
  localparam int CW    = $clog2(Iters);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q, rem_d;
  logic [63:0]   dvd_q, dvd_d;
  logic [31:0]   dvs_q;
  logic          neg_q;
  logic [32:0]   sh;
  logic          last;
  logic signed [65:0] mag, quot_w;

  assign last = (cnt_q == CW'(Iters - 1));

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    sh    = '0;
    for (int k = 0; k < Steps; k++) begin
      sh    = {rem_d, dvd_d[63]};
      dvd_d = {dvd_d[62:0], 1'b0};
      if (sh >= {1'b0, dvs_q}) begin
        rem_d    = 32'(sh - {1'b0, dvs_q});
        dvd_d[0] = 1'b1;
      end else begin
        rem_d = sh[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[63];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign mag    = signed'({2'b00, dvd_q});
  assign quot_w = neg_q ? -mag : mag;
  assign quot_o = sat32(quot_w);
  assign done_o = done_q;

  `ASSERT_CHK(div_rem_below_divisor_a, busy_q |-> (rem_q < dvs_q))
  `ASSERT_CHK(div_start_when_free_a, start_i |-> !busy_q)
  `ASSERT_CHK(div_done_pulse_a, done_q |=> !done_q)

endmodule
